[rtl/i2p_pkg.sv]
// Package for the infix to postfix converter: beat types, token and result
// codes, controller/datapath interface structs and the precedence lookup.
// Used by every module in rtl/.
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int PREC_W      = 36;

    localparam logic [PREC_W-1:0] PREC_RESET = 36'h885ADBBAA;

    // Token kinds on the input channel.
    localparam logic [1:0] TOK_OPERAND = 2'd0;
    localparam logic [1:0] TOK_OPERATOR = 2'd1;
    localparam logic [1:0] TOK_STMT_END = 2'd2;
    localparam logic [1:0] TOK_EOF      = 2'd3;

    // Result kinds on the output channel.
    localparam logic [1:0] OUT_OPERAND  = 2'd0;
    localparam logic [1:0] OUT_OPERATOR = 2'd1;
    localparam logic [1:0] OUT_END      = 2'd2;
    localparam logic [1:0] OUT_OVERFLOW = 2'd3;

    localparam logic [5:0] CODE_OPEN   = 6'd0;
    localparam logic [5:0] CODE_CLOSE  = 6'd1;
    localparam logic [5:0] CODE_FIRST  = 6'd2;
    localparam logic [5:0] CODE_LAST   = 6'd10;

    // Work modes, chosen once when a token is accepted.
    localparam logic [2:0] MODE_OPERAND   = 3'd0;
    localparam logic [2:0] MODE_FLUSH_END = 3'd1;
    localparam logic [2:0] MODE_FLUSH     = 3'd2;
    localparam logic [2:0] MODE_PUSH      = 3'd3;
    localparam logic [2:0] MODE_CLOSE     = 3'd4;
    localparam logic [2:0] MODE_PREC      = 3'd5;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [5:0]  operator_code;
        logic [15:0] operand_handle;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [5:0]  out_operator;
        logic [15:0] out_operand;
        logic        last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic new_valid;
        logic hold_valid;
        logic final_step;
    } t_dp_status;

    function automatic logic [3:0] level_of(input logic [PREC_W-1:0] prec,
                                            input logic [5:0] code);
        int base;
        base = 4 * (int'(code) - 2);
        if (code < CODE_FIRST || code > CODE_LAST) begin
            return 4'd0;
        end
        return prec[base +: 4];
    endfunction

endpackage

[rtl/infix_to_postfix_converter.sv]
// Top level of the infix to postfix converter: controller plus datapath.
// Depends on i2p_pkg, i2p_ctrl and i2p_datapath.
//
// Usage:
// Tokens arrive on the input channel (i_in_valid, o_in_stall, i_in) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out),
// one beat per token or result. A beat moves when valid is high and stall
// is low. The precedence table is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this. A token is taken only in the
// idle state; it then runs one stack step per cycle while the output is
// free. An operand token's result is placed in the output register by its
// single step. A token whose last step leaves two results to send (a
// statement end after a flush) sends the held one from a finish state.
// The single operator stack port allows at most one pop per step.
// One result is held back in the hold register so that last_of_run is
// known when it is sent. A stalled receiver holds the output register and
// pauses the steps; a new token is still taken while the last result
// waits to be read. Reset empties the stack, clears both valids and
// restores the default precedence levels; stack contents need no clearing.
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out,
    input  logic              i_cfg_wr_en,
    input  logic [PREC_W-1:0] i_cfg_wr_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    i2p_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out),
        .o_status      (status)
    );

endmodule

[rtl/i2p_ctrl.sv]
// Controller of the infix to postfix converter: sequences accept, stack
// steps and the final hand-off of a held result. Depends on i2p_pkg.
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.final_step) begin
                    // Two results left at once: one goes to the output register now, the other from the finish state.
                    if (i_status.new_valid && i_status.hold_valid) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/i2p_datapath.sv]
// Datapath of the infix to postfix converter: precedence register, operator
// stack, token register, one held result and the output register.
// Depends on i2p_pkg.
module i2p_datapath
    import i2p_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  t_in_beat          i_in,
    input  logic              i_cfg_wr_en,
    input  logic [PREC_W-1:0] i_cfg_wr_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_beat         o_out,
    output t_dp_status        o_status
);

    logic [PREC_W-1:0] r_prec;
    logic [5:0]        r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    t_in_beat          r_tok;
    logic [2:0]        r_mode;
    t_out_beat         r_hold;
    logic              r_hold_valid;
    t_out_beat         r_out;
    logic              r_out_valid;

    logic [2:0]       n_mode;
    t_out_beat        n_hold;
    logic             n_hold_valid;
    t_out_beat        n_out;
    logic             n_out_valid;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] top_idx;
    logic [5:0]       top;
    logic             empty;
    logic             full;
    logic             do_pop;
    logic             do_push;
    logic             new_valid;
    t_out_beat        new_item;
    logic             final_step;
    logic             out_free;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign top_idx  = cnt_m1[IDX_W-1:0];
    assign top      = r_stack[top_idx];
    assign empty    = (r_count == '0);
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;

    // The branch a token takes depends on the stack as it stands at accept.
    always_comb begin
        unique case (i_in.token_kind)
            TOK_OPERAND:  n_mode = MODE_OPERAND;
            TOK_STMT_END: n_mode = MODE_FLUSH_END;
            TOK_EOF:      n_mode = MODE_FLUSH;
            default: begin
                if (empty || i_in.operator_code == CODE_OPEN) begin
                    n_mode = MODE_PUSH;
                end else if (i_in.operator_code == CODE_CLOSE) begin
                    n_mode = MODE_CLOSE;
                end else begin
                    n_mode = MODE_PREC;
                end
            end
        endcase
    end

    // One stack step: at most one pop or push and at most one new result.
    always_comb begin
        do_pop     = 1'b0;
        do_push    = 1'b0;
        new_valid  = 1'b0;
        new_item   = '0;
        final_step = 1'b0;
        unique case (r_mode) inside
            MODE_OPERAND: begin
                new_valid            = 1'b1;
                new_item.out_kind    = OUT_OPERAND;
                new_item.out_operand = r_tok.operand_handle;
                final_step           = 1'b1;
            end
            MODE_FLUSH_END, MODE_FLUSH: begin
                if (!empty) begin
                    do_pop                = 1'b1;
                    new_valid             = 1'b1;
                    new_item.out_kind     = OUT_OPERATOR;
                    new_item.out_operator = top;
                end else begin
                    final_step = 1'b1;
                    if (r_mode == MODE_FLUSH_END) begin
                        new_valid         = 1'b1;
                        new_item.out_kind = OUT_END;
                    end
                end
            end
            MODE_CLOSE: begin
                if (empty) begin
                    final_step = 1'b1;
                end else begin
                    do_pop = 1'b1;
                    if (top == CODE_OPEN) begin
                        final_step = 1'b1;
                    end else begin
                        new_valid             = 1'b1;
                        new_item.out_kind     = OUT_OPERATOR;
                        new_item.out_operator = top;
                    end
                end
            end
            MODE_PREC, MODE_PUSH: begin
                if (r_mode == MODE_PREC && !empty &&
                    level_of(r_prec, top) >= level_of(r_prec, r_tok.operator_code)) begin
                    do_pop                = 1'b1;
                    new_valid             = 1'b1;
                    new_item.out_kind     = OUT_OPERATOR;
                    new_item.out_operator = top;
                end else begin
                    final_step = 1'b1;
                    if (full) begin
                        new_valid         = 1'b1;
                        new_item.out_kind = OUT_OVERFLOW;
                    end else begin
                        do_push = 1'b1;
                    end
                end
            end
            default: begin
                final_step = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        if (i_cmd.step) begin
            // A held result is sent only once it is known whether more follow.
            if (new_valid && r_hold_valid) begin
                n_out             = r_hold;
                n_out.last_of_run = 1'b0;
                n_out_valid       = 1'b1;
                n_hold            = new_item;
            end else if (new_valid && final_step) begin
                n_out             = new_item;
                n_out.last_of_run = 1'b1;
                n_out_valid       = 1'b1;
            end else if (new_valid) begin
                n_hold       = new_item;
                n_hold_valid = 1'b1;
            end else if (final_step && r_hold_valid) begin
                n_out             = r_hold;
                n_out.last_of_run = 1'b1;
                n_out_valid       = 1'b1;
                n_hold_valid      = 1'b0;
            end
        end
        if (i_cmd.finish) begin
            n_out             = r_hold;
            n_out.last_of_run = 1'b1;
            n_out_valid       = 1'b1;
            n_hold_valid      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && do_push) begin
            r_stack[r_count[IDX_W-1:0]] <= r_tok.operator_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tok <= i_in;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec       <= PREC_RESET;
            r_count      <= '0;
            r_mode       <= MODE_OPERAND;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prec <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_mode <= n_mode;
            end
            if (i_cmd.step) begin
                if (do_pop) begin
                    r_count <= cnt_m1;
                end else if (do_push) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;
    assign o_status.out_free   = out_free;
    assign o_status.new_valid  = new_valid;
    assign o_status.hold_valid = r_hold_valid;
    assign o_status.final_step = final_step;

endmodule
